### hw/rtl/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants for the segment intersection point block.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam int OUT_W   = 24;
   localparam int RSP_W   = 2 * OUT_W;

   typedef logic [OUT_W-1:0] point_type;

endpackage
`default_nettype wire

### hw/rtl/sip_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_div_cell
// One restoring-division step for both axes; resolves one quotient bit.
// ----------------------------------------------------------------------------
module sip_div_cell #(
   parameter int NW    = 51,
   parameter int DVW   = 34,
   parameter int QB    = 25,
   parameter int SHIFT = 0,
   parameter int SW    = 35
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output      logic          in_ready,
   input  wire logic [NW-1:0] in_rem_x,
   input  wire logic [NW-1:0] in_rem_y,
   input  wire logic [QB-1:0] in_q_x,
   input  wire logic [QB-1:0] in_q_y,
   input  wire logic [DVW-1:0] in_div,
   input  wire logic [SW-1:0] in_side,
   output      logic          out_valid,
   input  wire logic          out_ready,
   output      logic [NW-1:0] out_rem_x,
   output      logic [NW-1:0] out_rem_y,
   output      logic [QB-1:0] out_q_x,
   output      logic [QB-1:0] out_q_y,
   output      logic [DVW-1:0] out_div,
   output      logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [NW-1:0] rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QB-1:0] q_x_ff, q_y_ff, q_x_in, q_y_in;
   logic [DVW-1:0] div_ff;
   logic [SW-1:0] side_ff;
   logic [NW-1:0] dsh;
   logic          ge_x, ge_y;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dsh      = NW'(in_div) << SHIFT;
      ge_x     = in_rem_x >= dsh;
      ge_y     = in_rem_y >= dsh;
      rem_x_in = ge_x ? in_rem_x - dsh : in_rem_x;
      rem_y_in = ge_y ? in_rem_y - dsh : in_rem_y;
      q_x_in   = {in_q_x[QB-2:0], ge_x};
      q_y_in   = {in_q_y[QB-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         div_ff   <= in_div;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

### hw/rtl/segment_intersection_point.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection of segments AB and CD, point in signed fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req_    | in  | tdata: a_x a_y b_x b_y c_x c_y d_x d_y
//  rsp_    | out | tuser: hit; tdata: point_x point_y
//
//  One word per cycle while rsp_tready does not stall the output; the row
//  of divider cells resolves one quotient bit per cell.
//  Every stage has its own valid; bubbles collapse, a stalled output only
//  backs up the row once it is full. Synchronous reset clears valids.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
   input  wire logic [8*COORD_BITS-1:0] req_tdata,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // hit
   output      logic                    rsp_tuser,
   // point_x, point_y
   output      logic [sip_pkg::RSP_W-1:0] rsp_tdata
);
   import sip_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DW  = C + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = 2 * C + 3;
   localparam int MW  = XW - 1;
   localparam int NW  = MW + DW + F;
   localparam int QB  = C + F + 1;
   localparam int EW  = (C + F + 2 > OUT_W) ? C + F + 2 : OUT_W;
   localparam int SW  = 3 + 2 * C;

   // stage 1: differences
   logic v1_ff, r1;
   logic signed [DW-1:0] abx_ff, aby_ff, cdx_ff, cdy_ff, cax_ff, cay_ff;
   logic signed [C-1:0]  ax1_ff, ay1_ff;
   logic signed [C-1:0]  ax, ay, bx, by, cx, cy, dx, dy;

   // stage 2: products
   logic v2_ff, r2;
   logic signed [PW-1:0] p_ab_cd_ff, p_ba_dc_ff, p_ca_cd_ff, p_ac_dc_ff;
   logic signed [PW-1:0] p_ab_ca_ff, p_ba_ac_ff;
   logic signed [DW-1:0] abx2_ff, aby2_ff;
   logic signed [C-1:0]  ax2_ff, ay2_ff;

   // stage 3: cross products
   logic v3_ff, r3;
   logic signed [XW-1:0] deno_ff, sn_ff, tn_ff;
   logic signed [DW-1:0] abx3_ff, aby3_ff;
   logic signed [C-1:0]  ax3_ff, ay3_ff;

   // stage 4: checks and numerators
   logic v4_ff, r4;
   logic                 hit_in;
   logic [MW-1:0]        msn, mdn;
   logic [DW-1:0]        mdx, mdy;
   logic [NW-1:0]        nx_ff, ny_ff;
   logic [MW-1:0]        dn_ff;
   logic [SW-1:0]        side_ff, side_in;

   // divider row
   logic          ch_v [0:QB];
   logic          ch_r [0:QB];
   logic [NW-1:0] ch_rx [0:QB];
   logic [NW-1:0] ch_ry [0:QB];
   logic [QB-1:0] ch_qx [0:QB];
   logic [QB-1:0] ch_qy [0:QB];
   logic [MW-1:0] ch_d [0:QB];
   logic [SW-1:0] ch_s [0:QB];

   // output
   logic          ov_ff, ro;
   logic          hit_ff;
   point_type     px_ff, py_ff, px_in, py_in;
   logic signed [EW-1:0] bxe, bye, qxe, qye, sxe, sye;
   logic [SW-1:0] so;

   assign {dy, dx, cy, cx, by, bx, ay, ax} = req_tdata;

   assign ro = !ov_ff || rsp_tready;
   assign r4 = !v4_ff || ch_r[0];
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign req_tready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_tvalid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (ro) ov_ff <= ch_v[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && req_tvalid) begin
         abx_ff <= DW'(bx) - DW'(ax);
         aby_ff <= DW'(by) - DW'(ay);
         cdx_ff <= DW'(dx) - DW'(cx);
         cdy_ff <= DW'(dy) - DW'(cy);
         cax_ff <= DW'(cx) - DW'(ax);
         cay_ff <= DW'(cy) - DW'(ay);
         ax1_ff <= ax;
         ay1_ff <= ay;
      end
      if (r2 && v1_ff) begin
         p_ab_cd_ff <= PW'(abx_ff) * PW'(cdy_ff);
         p_ba_dc_ff <= PW'(aby_ff) * PW'(cdx_ff);
         p_ca_cd_ff <= PW'(cax_ff) * PW'(cdy_ff);
         p_ac_dc_ff <= PW'(cay_ff) * PW'(cdx_ff);
         p_ab_ca_ff <= PW'(aby_ff) * PW'(cax_ff);
         p_ba_ac_ff <= PW'(abx_ff) * PW'(cay_ff);
         abx2_ff    <= abx_ff;
         aby2_ff    <= aby_ff;
         ax2_ff     <= ax1_ff;
         ay2_ff     <= ay1_ff;
      end
      if (r3 && v2_ff) begin
         deno_ff <= XW'(p_ab_cd_ff) - XW'(p_ba_dc_ff);
         sn_ff   <= XW'(p_ca_cd_ff) - XW'(p_ac_dc_ff);
         tn_ff   <= XW'(p_ab_ca_ff) - XW'(p_ba_ac_ff);
         abx3_ff <= abx2_ff;
         aby3_ff <= aby2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
      end
      if (r4 && v3_ff) begin
         nx_ff   <= (NW'(msn) * NW'(mdx)) << F;
         ny_ff   <= (NW'(msn) * NW'(mdy)) << F;
         dn_ff   <= mdn;
         side_ff <= side_in;
      end
   end

   always_comb begin
      if (deno_ff > 0) begin
         hit_in = sn_ff >= 0 && sn_ff <= deno_ff && tn_ff >= 0 && tn_ff <= deno_ff;
      end else begin
         hit_in = deno_ff != 0 && sn_ff <= 0 && sn_ff >= deno_ff
                  && tn_ff <= 0 && tn_ff >= deno_ff;
      end
      msn = MW'(sn_ff[XW-1] ? -sn_ff : sn_ff);
      mdn = MW'(deno_ff[XW-1] ? -deno_ff : deno_ff);
      mdx = abx3_ff[DW-1] ? -abx3_ff : abx3_ff;
      mdy = aby3_ff[DW-1] ? -aby3_ff : aby3_ff;
      side_in = {hit_in,
                 sn_ff[XW-1] ^ abx3_ff[DW-1] ^ deno_ff[XW-1],
                 sn_ff[XW-1] ^ aby3_ff[DW-1] ^ deno_ff[XW-1],
                 ay3_ff, ax3_ff};
   end

   assign ch_v[0]  = v4_ff;
   assign ch_rx[0] = nx_ff;
   assign ch_ry[0] = ny_ff;
   assign ch_qx[0] = '0;
   assign ch_qy[0] = '0;
   assign ch_d[0]  = dn_ff;
   assign ch_s[0]  = side_ff;
   assign ch_r[QB] = ro;

   for (genvar k = 0; k < QB; k++) begin : g_cell
      sip_div_cell #(
         .NW(NW), .DVW(MW), .QB(QB), .SHIFT(QB - 1 - k), .SW(SW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_v[k]),
         .in_ready  (ch_r[k]),
         .in_rem_x  (ch_rx[k]),
         .in_rem_y  (ch_ry[k]),
         .in_q_x    (ch_qx[k]),
         .in_q_y    (ch_qy[k]),
         .in_div    (ch_d[k]),
         .in_side   (ch_s[k]),
         .out_valid (ch_v[k+1]),
         .out_ready (ch_r[k+1]),
         .out_rem_x (ch_rx[k+1]),
         .out_rem_y (ch_ry[k+1]),
         .out_q_x   (ch_qx[k+1]),
         .out_q_y   (ch_qy[k+1]),
         .out_div   (ch_d[k+1]),
         .out_side  (ch_s[k+1])
      );
   end

   always_comb begin
      so  = ch_s[QB];
      bxe = EW'($signed(so[C-1:0])) <<< F;
      bye = EW'($signed(so[2*C-1:C])) <<< F;
      qxe = EW'(ch_qx[QB]);
      qye = EW'(ch_qy[QB]);
      sxe = so[2*C+1] ? -qxe : qxe;
      sye = so[2*C]   ? -qye : qye;
      px_in = so[2*C+2] ? OUT_W'(bxe + sxe) : '0;
      py_in = so[2*C+2] ? OUT_W'(bye + sye) : '0;
   end

   always_ff @(posedge clock) begin
      if (ro && ch_v[QB]) begin
         hit_ff <= so[2*C+2];
         px_ff  <= px_in;
         py_ff  <= py_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {py_ff, px_ff};

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero point");

   a_backup : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while output free");

   a_reset_clear : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

endmodule
`default_nettype wire
